// ----- rtl/salru_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the set-associative LRU cache tag model.
// Used by the top level; depends on nothing.
package salru_pkg;

	// Width of a stored tag and of an LRU rank.
	localparam int TAG_W  = 62;
	localparam int RANK_W = 3;
	localparam logic [RANK_W-1:0] RANK_TOP = 3'd7;

	// Width of the saturating running totals.
	localparam int TOTAL_W = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_BLOCK_BITS = 2'd1,
		CFG_WAYS       = 2'd2
	} cfg_idx_t;

	// Access kinds carried by an input word.
	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_STORE  = 2'd1,
		FUNC_MODIFY = 2'd2,
		FUNC_IFETCH = 2'd3
	} func_t;

endpackage

// ----- rtl/set_assoc_cache_lru_model.sv -----
`timescale 1ns / 1ps
// Top level of the set-associative cache tag model with true LRU replacement.
// Depends on salru_pkg and salru_ram.
//
// Usage:
//   A word is taken at a rising edge where start is high and busy is low; it
//   carries an access kind (func) and a byte address. Instruction fetches pass
//   through without touching the set rows or the totals. Modify counts as a
//   lookup followed by a second lookup that always hits.
//   Each word gives exactly one result. done rises at the rising edge after
//   the word was taken, together with the registered result, which the
//   receiver takes while done is high. The receiver cannot stall results.
//   A new word is taken only once the last one is through: the set row is
//   read from the synchronous set memory at the edge that takes the word,
//   then looked up, updated and written back while busy is high.
//   Configuration (set_bits, block_bits, ways) is written through cfg_we,
//   cfg_index and cfg_wdata; the user must do so only while the block is idle;
//   the block does not check it. Indexes beyond the register list are ignored.
//   Reset clears the configuration to its defaults, the running totals and a
//   per-set row-valid flag; a set whose flag is clear reads as all lines
//   invalid, so no clearing pass is needed and words are taken at once.
module set_assoc_cache_lru_model #(
	parameter int MAX_SET_BITS  = 8,
	parameter int MAX_WAYS      = 8,
	parameter int ADDRESS_WIDTH = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [salru_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [salru_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            func,
	input  logic [ADDRESS_WIDTH-1:0]              address,
	output logic                                  done,
	output logic [1:0]                            hits_now,
	output logic                                  miss_now,
	output logic                                  evict_now,
	output logic [salru_pkg::TOTAL_W-1:0]         total_hits,
	output logic [salru_pkg::TOTAL_W-1:0]         total_misses,
	output logic [salru_pkg::TOTAL_W-1:0]         total_evictions
);

	localparam int SETS   = 2 ** MAX_SET_BITS;
	localparam int SET_W  = MAX_SET_BITS;
	localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WN_W   = $clog2(MAX_WAYS + 1);
	localparam int TAG_W  = salru_pkg::TAG_W;
	localparam int RANK_W = salru_pkg::RANK_W;
	localparam int LINE_W = 1 + TAG_W + RANK_W;
	localparam int ROW_W  = MAX_WAYS * LINE_W;
	localparam int TW     = salru_pkg::TOTAL_W;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [3:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_q;

	// Captured word.
	salru_pkg::func_t  func_q;
	logic [SET_W-1:0]  set_q;
	logic [TAG_W-1:0]  tag_q;

	// Per-set flag: the row has been written since reset.
	logic [SETS-1:0] row_ok_q;

	logic [TW-1:0] hit_total_q;
	logic [TW-1:0] miss_total_q;
	logic [TW-1:0] evict_total_q;

	logic accept;
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Effective set bits and ways in use.
	logic [SB_W-1:0] s_eff;
	logic [WN_W-1:0] n_eff;

	always_comb begin
		if (int'(set_bits_q) > MAX_SET_BITS) begin
			s_eff = SB_W'(MAX_SET_BITS);
		end else begin
			s_eff = SB_W'(set_bits_q);
		end
		if (ways_q == 4'd0) begin
			n_eff = WN_W'(1);
		end else if (int'(ways_q) > MAX_WAYS) begin
			n_eff = WN_W'(MAX_WAYS);
		end else begin
			n_eff = WN_W'(ways_q);
		end
	end

	// Split the address into set index and tag.
	logic [ADDRESS_WIDTH-1:0] above_c;
	logic [ADDRESS_WIDTH-1:0] tag_wide_c;
	logic [SET_W-1:0]         set_c;
	logic [TAG_W-1:0]         tag_c;

	always_comb begin
		above_c    = address >> block_bits_q;
		set_c      = SET_W'(above_c) & ~({SET_W{1'b1}} << s_eff);
		tag_wide_c = above_c >> s_eff;
		tag_c      = TAG_W'(tag_wide_c);
	end

	// Set memory: one row holds every way of a set.
	logic             ram_we;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] ram_rdata;

	salru_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SETS)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(set_q),
		.wdata(ram_wdata),
		.raddr(set_c),
		.rdata(ram_rdata)
	);

	// Unpack the row; a set never written reads as all lines invalid.
	logic [MAX_WAYS-1:0]             v_c;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  t_c;
	logic [MAX_WAYS-1:0][RANK_W-1:0] r_c;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (row_ok_q[set_q]) begin
				v_c[i] = ram_rdata[i*LINE_W + TAG_W + RANK_W];
				t_c[i] = ram_rdata[i*LINE_W + RANK_W +: TAG_W];
				r_c[i] = ram_rdata[i*LINE_W +: RANK_W];
			end else begin
				v_c[i] = 1'b0;
				t_c[i] = '0;
				r_c[i] = '0;
			end
		end
	end

	// Lookup: first matching way, first invalid way, least recently used way.
	logic              hit_c;
	logic [WAY_W-1:0]  hit_way_c;
	logic              inv_c;
	logic [WAY_W-1:0]  inv_way_c;
	logic [WAY_W-1:0]  lru_way_c;
	logic [RANK_W-1:0] best_c;
	logic [WAY_W-1:0]  touch_c;
	logic              evict_c;
	logic [RANK_W:0]   old_c;

	always_comb begin
		hit_c     = 1'b0;
		hit_way_c = '0;
		inv_c     = 1'b0;
		inv_way_c = '0;
		lru_way_c = '0;
		best_c    = r_c[0];
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (i < int'(n_eff)) begin
				if (!hit_c && v_c[i] && (t_c[i] == tag_q)) begin
					hit_c     = 1'b1;
					hit_way_c = WAY_W'(i);
				end
				if (!inv_c && !v_c[i]) begin
					inv_c     = 1'b1;
					inv_way_c = WAY_W'(i);
				end
				if (r_c[i] > best_c) begin
					best_c    = r_c[i];
					lru_way_c = WAY_W'(i);
				end
			end
		end
		if (hit_c) begin
			touch_c = hit_way_c;
		end else if (inv_c) begin
			touch_c = inv_way_c;
		end else begin
			touch_c = lru_way_c;
		end
		evict_c = !hit_c && !inv_c;
		if (v_c[touch_c]) begin
			old_c = {1'b0, r_c[touch_c]};
		end else begin
			old_c = {1'b1, {RANK_W{1'b0}}};
		end
	end

	// Age the other lines that were more recent than the touched one, promote it and pack the row again.
	always_comb begin
		ram_wdata = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (WAY_W'(i) == touch_c) begin
				ram_wdata[i*LINE_W + TAG_W + RANK_W] = 1'b1;
				ram_wdata[i*LINE_W + RANK_W +: TAG_W] = tag_q;
				ram_wdata[i*LINE_W +: RANK_W]         = '0;
			end else begin
				ram_wdata[i*LINE_W + TAG_W + RANK_W] = v_c[i];
				ram_wdata[i*LINE_W + RANK_W +: TAG_W] = t_c[i];
				if ((i < int'(n_eff)) && v_c[i] && ({1'b0, r_c[i]} < old_c)
						&& (r_c[i] < salru_pkg::RANK_TOP)) begin
					ram_wdata[i*LINE_W +: RANK_W] = r_c[i] + RANK_W'(1);
				end else begin
					ram_wdata[i*LINE_W +: RANK_W] = r_c[i];
				end
			end
		end
	end

	logic look_act;
	assign look_act = (state_q == ST_LOOK) && (func_q != salru_pkg::FUNC_IFETCH);
	assign ram_we   = look_act;

	// Counts of this word and saturating totals.
	logic [1:0]    hits_c;
	logic [TW:0]   hit_sum_c;
	logic [TW:0]   miss_sum_c;
	logic [TW:0]   evict_sum_c;
	logic [TW-1:0] hit_next_c;
	logic [TW-1:0] miss_next_c;
	logic [TW-1:0] evict_next_c;

	always_comb begin
		if (func_q == salru_pkg::FUNC_MODIFY) begin
			hits_c = hit_c ? 2'd2 : 2'd1;
		end else begin
			hits_c = hit_c ? 2'd1 : 2'd0;
		end
		hit_sum_c    = {1'b0, hit_total_q} + (TW+1)'(hits_c);
		miss_sum_c   = {1'b0, miss_total_q} + (TW+1)'(!hit_c);
		evict_sum_c  = {1'b0, evict_total_q} + (TW+1)'(evict_c);
		hit_next_c   = hit_sum_c[TW] ? {TW{1'b1}} : hit_sum_c[TW-1:0];
		miss_next_c  = miss_sum_c[TW] ? {TW{1'b1}} : miss_sum_c[TW-1:0];
		evict_next_c = evict_sum_c[TW] ? {TW{1'b1}} : evict_sum_c[TW-1:0];
	end

	// Capture the word when it is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= salru_pkg::func_t'(func);
			set_q  <= set_c;
			tag_q  <= tag_c;
		end
	end

	// Sequencer, configuration, totals and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			set_bits_q    <= 4'd4;
			block_bits_q  <= 6'd4;
			ways_q        <= 4'd1;
			row_ok_q      <= '0;
			hit_total_q   <= '0;
			miss_total_q  <= '0;
			evict_total_q <= '0;
			done          <= 1'b0;
			hits_now      <= '0;
			miss_now      <= 1'b0;
			evict_now     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					salru_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_wdata[3:0];
					salru_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_wdata;
					salru_pkg::CFG_WAYS:       ways_q       <= cfg_wdata[3:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					done <= 1'b0;
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
					if (look_act) begin
						row_ok_q[set_q] <= 1'b1;
						hit_total_q     <= hit_next_c;
						miss_total_q    <= miss_next_c;
						evict_total_q   <= evict_next_c;
						hits_now        <= hits_c;
						miss_now        <= !hit_c;
						evict_now       <= evict_c;
					end else begin
						hits_now  <= '0;
						miss_now  <= 1'b0;
						evict_now <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					done    <= 1'b0;
				end
			endcase
		end
	end

	assign total_hits      = hit_total_q;
	assign total_misses    = miss_total_q;
	assign total_evictions = evict_total_q;

endmodule

// ----- rtl/salru_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// Standalone; used by the cache tag model for its set rows.
module salru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sim/set_assoc_cache_lru_model_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_cache_lru_model: a stimulus table and random access
// phases under several cache geometries, each result checked against typed-in counts or a
// behavioural LRU model. Depends on salru_pkg and the set_assoc_cache_lru_model RTL.
module set_assoc_cache_lru_model_test;

	localparam int SETS_MAX   = 8;
	localparam int WAYS_MAX   = 8;
	localparam int LINES      = (1 << SETS_MAX) * WAYS_MAX;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 110;
	localparam int POOL_SIZE  = 24;
	localparam int CYCLE_CAP  = 400000;
	localparam int PLAN_LEN   = 20;

	// Counts that one access word produces.
	typedef struct packed {
		logic [1:0]  hits;
		logic        miss;
		logic        evict;
		logic [31:0] hit_sum;
		logic [31:0] miss_sum;
		logic [31:0] evict_sum;
	} counts_t;

	// One row of the directed table; reconfig applies the geometry before the word.
	typedef struct packed {
		bit               reconfig;
		logic [5:0]       set_v;
		logic [5:0]       block_v;
		logic [5:0]       ways_v;
		salru_pkg::func_t kind;
		logic [63:0]      addr;
		bit               check;
		counts_t          want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [salru_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = '0;
	logic [63:0] address = '0;
	logic        done;
	logic [1:0]  hits_now;
	logic        miss_now;
	logic        evict_now;
	logic [salru_pkg::TOTAL_W-1:0] total_hits;
	logic [salru_pkg::TOTAL_W-1:0] total_misses;
	logic [salru_pkg::TOTAL_W-1:0] total_evictions;

	// Model of the tag store, its geometry and the running totals.
	logic                         line_ok   [LINES];
	logic [salru_pkg::TAG_W-1:0]  line_key  [LINES];
	logic [salru_pkg::RANK_W-1:0] line_age  [LINES];
	logic [3:0]        geo_sets  = 4'd4;
	logic [5:0]        geo_block = 6'd4;
	logic [3:0]        geo_ways  = 4'd1;
	logic [31:0]       hit_sum   = '0;
	logic [31:0]       miss_sum  = '0;
	logic [31:0]       evict_sum = '0;

	counts_t     counts_due [$];
	logic [63:0] addr_pool [POOL_SIZE];
	int unsigned fail_count = 0;
	int unsigned words_sent = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;

	// Directed words: expectations are typed in for the first ten, which run from reset.
	plan_row_t plan [PLAN_LEN] = '{
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_LOAD, 64'h0, 1'b1,
			'{2'd0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0}},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_LOAD, 64'h8, 1'b1,
			'{2'd1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0}},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_STORE, 64'h100, 1'b1,
			'{2'd0, 1'b1, 1'b1, 32'd1, 32'd2, 32'd1}},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_MODIFY, 64'h200, 1'b1,
			'{2'd1, 1'b1, 1'b1, 32'd2, 32'd3, 32'd2}},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_MODIFY, 64'h208, 1'b1,
			'{2'd2, 1'b0, 1'b0, 32'd4, 32'd3, 32'd2}},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{2'd0, 1'b0, 1'b0, 32'd4, 32'd3, 32'd2}},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{2'd0, 1'b1, 1'b0, 32'd4, 32'd4, 32'd2}},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{2'd1, 1'b0, 1'b0, 32'd5, 32'd4, 32'd2}},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_LOAD, 64'h8000_0000_0000_00F0, 1'b1,
			'{2'd0, 1'b1, 1'b1, 32'd5, 32'd5, 32'd3}},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_IFETCH, 64'h0, 1'b1,
			'{2'd0, 1'b0, 1'b0, 32'd5, 32'd5, 32'd3}},
		'{1'b1, 6'd0, 6'd0, 6'd2, salru_pkg::FUNC_LOAD, 64'h1234, 1'b0, '0},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_LOAD, 64'hC000_0000_0000_1234, 1'b0, '0},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_STORE, 64'h5678, 1'b0, '0},
		'{1'b1, 6'd15, 6'd63, 6'd0, salru_pkg::FUNC_LOAD, 64'hDEAD_BEEF_0000_0001, 1'b0, '0},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_MODIFY, 64'h1, 1'b0, '0},
		'{1'b1, 6'd8, 6'd32, 6'd15, salru_pkg::FUNC_LOAD, 64'hFFFF_FFFF_0000_0000, 1'b0, '0},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_STORE, 64'h0000_0012_0000_0000, 1'b0, '0},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{1'b0, 6'd0, 6'd0, 6'd0, salru_pkg::FUNC_IFETCH, 64'h5555_5555_5555_5555, 1'b0, '0},
		'{1'b1, 6'd1, 6'd1, 6'd8, salru_pkg::FUNC_LOAD, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0}
	};

	// Geometry of the first random phases; the later ones are drawn at random.
	logic [5:0] phase_sets  [6] = '{6'd4, 6'd0, 6'd8, 6'd63, 6'd2, 6'd1};
	logic [5:0] phase_block [6] = '{6'd4, 6'd0, 6'd1, 6'd32, 6'd63, 6'd5};
	logic [5:0] phase_ways  [6] = '{6'd4, 6'd8, 6'd2, 6'd63, 6'd0, 6'd8};

	set_assoc_cache_lru_model dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.address         (address),
		.done            (done),
		.hits_now        (hits_now),
		.miss_now        (miss_now),
		.evict_now       (evict_now),
		.total_hits      (total_hits),
		.total_misses    (total_misses),
		.total_evictions (total_evictions)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int unsigned sets_live();
		return (geo_sets > SETS_MAX) ? SETS_MAX : geo_sets;
	endfunction

	function automatic int unsigned ways_live();
		if (geo_ways == 0)
			return 1;
		return (geo_ways > WAYS_MAX) ? WAYS_MAX : geo_ways;
	endfunction

	// Make way w the most recent; valid ways younger than it was age by one.
	function automatic void make_recent(int unsigned base, int unsigned n, int unsigned w);
		int unsigned was;
		was = line_ok[base + w] ? line_age[base + w] : salru_pkg::RANK_TOP + 1;
		for (int unsigned i = 0; i < n; i++) begin
			if (i != w && line_ok[base + i] && line_age[base + i] < was &&
					line_age[base + i] < salru_pkg::RANK_TOP)
				line_age[base + i] = line_age[base + i] + 1'b1;
		end
		line_age[base + w] = '0;
	endfunction

	// One lookup in a set: hit, or fill an invalid way, or evict the oldest way.
	function automatic bit lookup_set(input int unsigned set_no,
			input logic [salru_pkg::TAG_W-1:0] key, output bit evicted);
		int unsigned n;
		int unsigned base;
		int unsigned victim;
		logic [salru_pkg::RANK_W-1:0] oldest;
		n = ways_live();
		base = set_no * WAYS_MAX;
		evicted = 1'b0;
		for (int unsigned w = 0; w < n; w++) begin
			if (line_ok[base + w] && line_key[base + w] == key) begin
				make_recent(base, n, w);
				return 1'b1;
			end
		end
		victim = n;
		for (int unsigned w = 0; w < n; w++) begin
			if (!line_ok[base + w] && victim == n)
				victim = w;
		end
		// Lowest way wins when several share the highest rank.
		if (victim == n) begin
			victim = 0;
			oldest = line_age[base];
			for (int unsigned w = 1; w < n; w++) begin
				if (line_age[base + w] > oldest) begin
					oldest = line_age[base + w];
					victim = w;
				end
			end
			evicted = 1'b1;
		end
		make_recent(base, n, victim);
		line_ok[base + victim] = 1'b1;
		line_key[base + victim] = key;
		return 1'b0;
	endfunction

	function automatic logic [31:0] add_capped(logic [31:0] acc, logic [1:0] inc);
		logic [32:0] wide;
		wide = {1'b0, acc} + inc;
		return wide[32] ? 32'hFFFF_FFFF : wide[31:0];
	endfunction

	// Counts of one access word; updates the tag store and the totals.
	function automatic counts_t access_counts(salru_pkg::func_t kind, logic [63:0] addr);
		counts_t res;
		logic [63:0] above;
		int unsigned s;
		int unsigned set_no;
		int unsigned rounds;
		bit evicted;
		res = '0;
		if (kind != salru_pkg::FUNC_IFETCH) begin
			s = sets_live();
			above = addr >> geo_block;
			set_no = int'(above & ((64'd1 << s) - 64'd1));
			rounds = (kind == salru_pkg::FUNC_MODIFY) ? 2 : 1;
			for (int unsigned r = 0; r < rounds; r++) begin
				if (lookup_set(set_no, salru_pkg::TAG_W'(above >> s), evicted)) begin
					res.hits = res.hits + 2'd1;
				end else begin
					res.miss = 1'b1;
					if (evicted)
						res.evict = 1'b1;
				end
			end
			hit_sum = add_capped(hit_sum, res.hits);
			miss_sum = add_capped(miss_sum, {1'b0, res.miss});
			evict_sum = add_capped(evict_sum, {1'b0, res.evict});
		end
		res.hit_sum = hit_sum;
		res.miss_sum = miss_sum;
		res.evict_sum = evict_sum;
		return res;
	endfunction

	// A new address aimed at a few sets and a few tags, sometimes fully random.
	function automatic logic [63:0] fresh_address();
		logic [63:0] noise;
		int unsigned s;
		noise = {$urandom, $urandom};
		s = sets_live();
		if ($urandom_range(0, 4) == 0)
			return noise;
		return (noise & ((64'd1 << geo_block) - 64'd1)) |
			(64'($urandom_range(0, 3)) << geo_block) |
			(64'($urandom_range(0, 11)) << (geo_block + s));
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Drive one word, hold it until taken, then queue its expected counts.
	task automatic send_word(input salru_pkg::func_t kind, input logic [63:0] addr,
			input bit typed, input counts_t want);
		counts_t model;
		start <= 1'b1;
		func <= kind;
		address <= addr;
		do
			@(posedge clk);
		while (busy);
		model = access_counts(kind, addr);
		counts_due.push_back(typed ? want : model);
		words_sent++;
	endtask

	task automatic idle_gap(input bit no_idle);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input salru_pkg::cfg_idx_t idx, input logic [5:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			salru_pkg::CFG_SET_BITS: geo_sets = value[3:0];
			salru_pkg::CFG_BLOCK_BITS: geo_block = value;
			salru_pkg::CFG_WAYS: geo_ways = value[3:0];
			default: ;
		endcase
	endtask

	// Let the block drain, then write all three geometry registers.
	task automatic reconfigure(input logic [5:0] s, input logic [5:0] b, input logic [5:0] w);
		start <= 1'b0;
		while (counts_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(salru_pkg::CFG_SET_BITS, s);
		write_reg(salru_pkg::CFG_BLOCK_BITS, b);
		write_reg(salru_pkg::CFG_WAYS, w);
		cfg_we <= 1'b0;
	endtask

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		counts_t want;
		if (arst_n && done) begin
			if (counts_due.size() == 0) begin
				$display("%0t ns: result word with no expectation waiting", $time);
				fail_count++;
			end else begin
				want = counts_due.pop_front();
				check_field("hits_now", want.hits, hits_now);
				check_field("miss_now", want.miss, miss_now);
				check_field("evict_now", want.evict, evict_now);
				check_field("total_hits", want.hit_sum, total_hits);
				check_field("total_misses", want.miss_sum, total_misses);
				check_field("total_evictions", want.evict_sum, total_evictions);
				results_seen++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("%0t ns: run timed out with %0d results outstanding", $time,
				counts_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus: reset, directed table, then random phases of accesses.
	initial begin
		logic [5:0] ps;
		logic [5:0] pb;
		logic [5:0] pw;
		logic [63:0] addr;
		salru_pkg::func_t kind;
		int unsigned slot;
		int unsigned pick;
		bit no_idle;
		for (int i = 0; i < LINES; i++) begin
			line_ok[i] = 1'b0;
			line_key[i] = '0;
			line_age[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words.
		foreach (plan[i]) begin
			if (plan[i].reconfig)
				reconfigure(plan[i].set_v, plan[i].block_v, plan[i].ways_v);
			idle_gap(1'b0);
			send_word(plan[i].kind, plan[i].addr, plan[i].check, plan[i].want);
		end

		// Random phases; most words revisit a small pool of addresses so that
		// sets fill up, hit and evict.
		for (int p = 0; p < PHASES; p++) begin
			if (p < 6) begin
				ps = phase_sets[p];
				pb = phase_block[p];
				pw = phase_ways[p];
			end else if ($urandom_range(0, 1) == 0) begin
				ps = $urandom_range(1, 8);
				pb = $urandom_range(1, 32);
				pw = $urandom_range(1, 8);
			end else begin
				ps = $urandom_range(0, 63);
				pb = $urandom_range(0, 63);
				pw = $urandom_range(0, 63);
			end
			reconfigure(ps, pb, pw);
			foreach (addr_pool[i])
				addr_pool[i] = fresh_address();
			no_idle = ($urandom_range(0, 2) == 0);
			for (int n = 0; n < PHASE_LEN; n++) begin
				pick = $urandom_range(0, 9);
				kind = (pick < 4) ? salru_pkg::FUNC_LOAD :
					(pick < 7) ? salru_pkg::FUNC_STORE :
					(pick < 9) ? salru_pkg::FUNC_MODIFY : salru_pkg::FUNC_IFETCH;
				slot = $urandom_range(0, POOL_SIZE - 1);
				if ($urandom_range(0, 9) < 6) begin
					addr = addr_pool[slot] ^
						({$urandom, $urandom} & ((64'd1 << geo_block) - 64'd1));
				end else begin
					addr = fresh_address();
					addr_pool[slot] = addr;
				end
				idle_gap(no_idle);
				send_word(kind, addr, 1'b0, '0);
			end
		end

		// Drain and report.
		start <= 1'b0;
		while (counts_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		$display("Sent %0d access words over %0d geometry phases plus the directed table;",
			words_sent, PHASES);
		$display("%0d result words checked, %0d mismatches.", results_seen, fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
